### src/tsfp_pkg.sv
// Shared types and constants of the tagged sensor frame parser.
package tsfp_pkg;

  localparam int unsigned RECORD_BYTES = 12;
  localparam int unsigned STAMP_BYTES  = 8;
  localparam int unsigned PULSE_END    = 10;
  localparam int unsigned RATE_BYTES   = 2;
  localparam int unsigned QUEUE_DEPTH  = 4;

  localparam logic [1:0] REG_MODE_TAG   = 2'd0;
  localparam logic [1:0] REG_MOOD_TAG   = 2'd1;
  localparam logic [1:0] REG_RATE_TAG   = 2'd2;
  localparam logic [1:0] REG_RECORD_TAG = 2'd3;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } tsfp_kind_e;

  typedef enum logic [1:0] {
    ERR_ORDER     = 2'd0,
    ERR_UNKNOWN   = 2'd1,
    ERR_TRUNCATED = 2'd2,
    ERR_NO_END    = 2'd3
  } tsfp_err_e;

  typedef struct packed {
    logic [7:0] mode_tag;
    logic [7:0] mood_tag;
    logic [7:0] rate_tag;
    logic [7:0] record_tag;
  } tsfp_tags_t;

  typedef struct packed {
    tsfp_kind_e  result_kind;
    logic [63:0] timestamp_ms;
    logic [15:0] heart_rate;
    logic [15:0] step_count;
    logic [7:0]  mode_value;
    logic [7:0]  mood_value;
    logic [15:0] average_rate;
    tsfp_err_e   error_code;
    logic        last_of_run;
  } tsfp_result_t;

endpackage

### src/tsfp_core.sv
// Frame parse state machine: consumes one byte per step and forms up to two results.
module tsfp_core
  import tsfp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   byte_value_i,
  input  logic         frame_end_i,
  input  tsfp_tags_t   tags_i,
  output logic [1:0]   res_count_o,
  output tsfp_result_t res0_o,
  output tsfp_result_t res1_o
);

  typedef enum logic [2:0] {
    PH_MODE_TAG   = 3'd0,
    PH_MODE_BYTE  = 3'd1,
    PH_MOOD_TAG   = 3'd2,
    PH_MOOD_BYTE  = 3'd3,
    PH_RATE_TAG   = 3'd4,
    PH_RATE_BYTES = 3'd5,
    PH_REC_TAG    = 3'd6,
    PH_REC_BYTES  = 3'd7
  } tsfp_phase_e;

  tsfp_phase_e  phase_q, phase_d;
  logic [3:0]   cnt_q, cnt_d, cnt_inc;
  logic         disc_q, disc_d;
  logic [7:0]   mode_q, mode_d, mood_q, mood_d;
  logic [15:0]  rate_q, rate_d;
  logic [63:0]  stamp_q, stamp_d;
  logic [15:0]  pulse_q, pulse_d, steps_q, steps_d;
  logic [7:0]   exp_tag;
  logic         tag_known;
  logic         rec_v, acc_v, err_v;
  tsfp_err_e    err_code;
  tsfp_result_t rec_res, acc_res, err_res;

  always_comb begin
    unique case (phase_q[2:1])
      2'd0: exp_tag = tags_i.mode_tag;
      2'd1: exp_tag = tags_i.mood_tag;
      2'd2: exp_tag = tags_i.rate_tag;
      default: exp_tag = tags_i.record_tag;
    endcase
  end

  assign tag_known = (byte_value_i == tags_i.mode_tag) || (byte_value_i == tags_i.mood_tag) ||
                     (byte_value_i == tags_i.rate_tag) || (byte_value_i == tags_i.record_tag);
  assign cnt_inc = cnt_q + 4'd1;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    disc_d   = disc_q;
    mode_d   = mode_q;
    mood_d   = mood_q;
    rate_d   = rate_q;
    stamp_d  = stamp_q;
    pulse_d  = pulse_q;
    steps_d  = steps_q;
    rec_v    = 1'b0;
    acc_v    = 1'b0;
    err_v    = 1'b0;
    err_code = ERR_ORDER;
    if (disc_q) begin
      if (frame_end_i) begin
        disc_d  = 1'b0;
        phase_d = PH_MODE_TAG;
        cnt_d   = '0;
      end
    end else begin
      unique case (phase_q)
        PH_MODE_TAG, PH_MOOD_TAG, PH_RATE_TAG, PH_REC_TAG: begin
          if (byte_value_i == exp_tag) begin
            cnt_d = '0;
            if (phase_q == PH_REC_TAG) begin
              if (frame_end_i) begin
                acc_v = 1'b1;
              end else begin
                phase_d = PH_REC_BYTES;
              end
            end else if (frame_end_i) begin
              err_v    = 1'b1;
              err_code = ERR_TRUNCATED;
            end else begin
              phase_d = tsfp_phase_e'(phase_q + 3'd1);
            end
          end else begin
            err_v    = 1'b1;
            err_code = tag_known ? ERR_ORDER : ERR_UNKNOWN;
            disc_d   = !frame_end_i;
          end
        end
        PH_MODE_BYTE: begin
          mode_d  = byte_value_i;
          phase_d = PH_MOOD_TAG;
          if (frame_end_i) begin
            err_v    = 1'b1;
            err_code = ERR_NO_END;
          end
        end
        PH_MOOD_BYTE: begin
          mood_d  = byte_value_i;
          phase_d = PH_RATE_TAG;
          if (frame_end_i) begin
            err_v    = 1'b1;
            err_code = ERR_NO_END;
          end
        end
        PH_RATE_BYTES: begin
          rate_d = {rate_q[7:0], byte_value_i};
          cnt_d  = cnt_inc;
          if (cnt_inc >= 4'(RATE_BYTES)) begin
            phase_d = PH_REC_TAG;
            cnt_d   = '0;
            if (frame_end_i) begin
              err_v    = 1'b1;
              err_code = ERR_NO_END;
            end
          end else if (frame_end_i) begin
            err_v    = 1'b1;
            err_code = ERR_TRUNCATED;
          end
        end
        PH_REC_BYTES: begin
          if (cnt_q < 4'(STAMP_BYTES)) begin
            stamp_d = {stamp_q[55:0], byte_value_i};
          end else if (cnt_q < 4'(PULSE_END)) begin
            pulse_d = {pulse_q[7:0], byte_value_i};
          end else begin
            steps_d = {steps_q[7:0], byte_value_i};
          end
          cnt_d = cnt_inc;
          if (cnt_inc >= 4'(RECORD_BYTES)) begin
            rec_v   = 1'b1;
            phase_d = PH_REC_TAG;
            cnt_d   = '0;
            if (frame_end_i) begin
              err_v    = 1'b1;
              err_code = ERR_NO_END;
            end
          end else if (frame_end_i) begin
            err_v    = 1'b1;
            err_code = ERR_TRUNCATED;
          end
        end
        default: begin
          phase_d = PH_MODE_TAG;
        end
      endcase
      // An error on the final byte never starts discarding, so the frame always closes here.
      if (frame_end_i) begin
        phase_d = PH_MODE_TAG;
        cnt_d   = '0;
      end
    end
  end

  always_comb begin
    rec_res              = '0;
    rec_res.result_kind  = KIND_RECORD;
    rec_res.timestamp_ms = stamp_d;
    rec_res.heart_rate   = pulse_d;
    rec_res.step_count   = steps_d;
    acc_res              = '0;
    acc_res.result_kind  = KIND_ACCEPT;
    acc_res.mode_value   = mode_q;
    acc_res.mood_value   = mood_q;
    acc_res.average_rate = rate_q;
    acc_res.last_of_run  = 1'b1;
    err_res              = '0;
    err_res.result_kind  = KIND_REJECT;
    err_res.error_code   = err_code;
    err_res.last_of_run  = 1'b1;
    res0_o      = '0;
    res1_o      = '0;
    res_count_o = 2'd0;
    if (rec_v) begin
      res0_o = rec_res;
      if (err_v) begin
        res1_o      = err_res;
        res_count_o = 2'd2;
      end else begin
        res0_o.last_of_run = 1'b1;
        res_count_o        = 2'd1;
      end
    end else if (acc_v) begin
      res0_o      = acc_res;
      res_count_o = 2'd1;
    end else if (err_v) begin
      res0_o      = err_res;
      res_count_o = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MODE_TAG;
      cnt_q   <= '0;
      disc_q  <= 1'b0;
      mode_q  <= '0;
      mood_q  <= '0;
      rate_q  <= '0;
      stamp_q <= '0;
      pulse_q <= '0;
      steps_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      disc_q  <= disc_d;
      mode_q  <= mode_d;
      mood_q  <= mood_d;
      rate_q  <= rate_d;
      stamp_q <= stamp_d;
      pulse_q <= pulse_d;
      steps_q <= steps_d;
    end
  end

endmodule

### src/tsfp_out_queue.sv
// Result queue that takes up to two results per cycle and hands out one.
module tsfp_out_queue
  import tsfp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [1:0]   push_count_i,
  input  tsfp_result_t push0_i,
  input  tsfp_result_t push1_i,
  input  logic         pop_i,
  output tsfp_result_t head_o,
  output logic         not_empty_o,
  output logic         has_room_o,
  output logic [2:0]   fill_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  tsfp_result_t          mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]       rd_q, wr_q, wr_next;
  logic [2:0]            cnt_q;

  assign wr_next     = wr_q + PtrW'(1);
  assign head_o      = mem_q[rd_q];
  assign not_empty_o = (cnt_q != 3'd0);
  assign has_room_o  = (cnt_q <= 3'(QUEUE_DEPTH - 2));
  assign fill_o      = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_count_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_count_i == 2'd2) begin
      mem_q[wr_next] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_count_i);
      rd_q  <= rd_q + PtrW'(pop_i);
      cnt_q <= cnt_q + 3'(push_count_i) - 3'(pop_i);
    end
  end

endmodule

### src/tagged_sensor_frame_parser.sv
// Top level of the tagged sensor frame parser: input register, tag registers, parser, queue.
// The input register holds an accepted word until the queue has room for two results; the
// parser then consumes it and writes its results into the queue, whose head drives the outputs.
// Throughput: one word per cycle while the queue has room and each word yields at most one result;
// a word with two results leaves through the single read port of the result queue one at a time.
// Reset clears the parse state and the queue and loads the tag registers with 1, 2, 3 and 4.
module tagged_sensor_frame_parser
  import tsfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [63:0] timestamp_ms_o,
  output logic [15:0] heart_rate_o,
  output logic [15:0] step_count_o,
  output logic [7:0]  mode_value_o,
  output logic [7:0]  mood_value_o,
  output logic [15:0] average_rate_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_run_o
);

  tsfp_tags_t   tags_q;
  logic         stage_v_q;
  logic [7:0]   stage_byte_q;
  logic         stage_end_q;
  logic         in_accept, advance, room, pop;
  logic [1:0]   res_count, push_count;
  tsfp_result_t res0, res1, head;
  logic [2:0]   fill;

  assign advance    = stage_v_q && room;
  assign in_stall_o = stage_v_q && !room;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign push_count = advance ? res_count : 2'd0;
  assign pop        = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tags_q <= '{mode_tag: 8'd1, mood_tag: 8'd2, rate_tag: 8'd3, record_tag: 8'd4};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MODE_TAG:   tags_q.mode_tag   <= cfg_data_i;
        REG_MOOD_TAG:   tags_q.mood_tag   <= cfg_data_i;
        REG_RATE_TAG:   tags_q.rate_tag   <= cfg_data_i;
        REG_RECORD_TAG: tags_q.record_tag <= cfg_data_i;
        default:        tags_q            <= tags_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else begin
      stage_v_q <= in_accept || (stage_v_q && !advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stage_byte_q <= byte_value_i;
      stage_end_q  <= frame_end_i;
    end
  end

  tsfp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_value_i (stage_byte_q),
    .frame_end_i  (stage_end_q),
    .tags_i       (tags_q),
    .res_count_o  (res_count),
    .res0_o       (res0),
    .res1_o       (res1)
  );

  tsfp_out_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_count_i (push_count),
    .push0_i      (res0),
    .push1_i      (res1),
    .pop_i        (pop),
    .head_o       (head),
    .not_empty_o  (out_valid_o),
    .has_room_o   (room),
    .fill_o       (fill)
  );

  assign result_kind_o  = head.result_kind;
  assign timestamp_ms_o = head.timestamp_ms;
  assign heart_rate_o   = head.heart_rate;
  assign step_count_o   = head.step_count;
  assign mode_value_o   = head.mode_value;
  assign mood_value_o   = head.mood_value;
  assign average_rate_o = head.average_rate;
  assign error_code_o   = head.error_code;
  assign last_of_run_o  = head.last_of_run;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= 3'(QUEUE_DEPTH))
    else $error("Result queue holds more entries than it has.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !last_of_run_o) |=> out_valid_o)
    else $error("The second result of a word did not follow the first.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (result_kind_o == KIND_ACCEPT || result_kind_o == KIND_REJECT))
      |-> last_of_run_o)
    else $error("A frame verdict was not the final result of its word.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_count == 2'd2) |-> (res0.result_kind == KIND_RECORD))
    else $error("A word with two results did not start with a record.");

endmodule

### verif/tsfp_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the tagged sensor frame parser bench: byte-level frame predictor and result checker.
package tsfp_tb_pkg;
  import tsfp_pkg::*;

  class tsfp_scoreboard;
    localparam logic [2:0] ST_MODE_TAG = 3'd0;
    localparam logic [2:0] ST_MODE     = 3'd1;
    localparam logic [2:0] ST_MOOD_TAG = 3'd2;
    localparam logic [2:0] ST_MOOD     = 3'd3;
    localparam logic [2:0] ST_RATE_TAG = 3'd4;
    localparam logic [2:0] ST_RATE     = 3'd5;
    localparam logic [2:0] ST_REC_TAG  = 3'd6;
    localparam logic [2:0] ST_REC      = 3'd7;

    logic [7:0]   tag_val[4];
    logic [2:0]   phase;
    logic [3:0]   count;
    logic [7:0]   mode_byte;
    logic [7:0]   mood_byte;
    logic [15:0]  avg_rate;
    logic [63:0]  stamp;
    logic [15:0]  pulse;
    logic [15:0]  steps;
    bit           skipping;
    tsfp_result_t expected_q[$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  bytes_in;
    int unsigned  kind_seen[3];
    int unsigned  err_seen[4];

    function new();
      tag_val[REG_MODE_TAG]   = 8'd1;
      tag_val[REG_MOOD_TAG]   = 8'd2;
      tag_val[REG_RATE_TAG]   = 8'd3;
      tag_val[REG_RECORD_TAG] = 8'd4;
      phase      = ST_MODE_TAG;
      count      = '0;
      mode_byte  = '0;
      mood_byte  = '0;
      avg_rate   = '0;
      stamp      = '0;
      pulse      = '0;
      steps      = '0;
      skipping   = 1'b0;
      mismatches = 0;
      checked    = 0;
      bytes_in   = 0;
      kind_seen  = '{0, 0, 0};
      err_seen   = '{0, 0, 0, 0};
    endfunction

    function void set_tag(logic [1:0] idx, logic [7:0] val);
      tag_val[idx] = val;
    endfunction

    function tsfp_result_t reject(tsfp_err_e code, logic fin);
      tsfp_result_t r;
      r = '0;
      r.result_kind = KIND_REJECT;
      r.error_code  = code;
      if (!fin) begin
        skipping = 1'b1;
      end
      return r;
    endfunction

    function string describe(tsfp_result_t r);
      return $sformatf("kind %0d ts %h hr %h st %h mode %h mood %h rate %h err %0d last %0b",
                       r.result_kind, r.timestamp_ms, r.heart_rate, r.step_count,
                       r.mode_value, r.mood_value, r.average_rate, r.error_code,
                       r.last_of_run);
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      tsfp_result_t run[2];
      tsfp_result_t r;
      int           n;
      n = 0;
      bytes_in++;
      if (skipping) begin
        if (fin) begin
          skipping = 1'b0;
          phase    = ST_MODE_TAG;
          count    = '0;
        end
        return;
      end
      if (!phase[0]) begin
        if (b == tag_val[phase[2:1]]) begin
          if (phase == ST_REC_TAG) begin
            if (fin) begin
              r = '0;
              r.result_kind  = KIND_ACCEPT;
              r.mode_value   = mode_byte;
              r.mood_value   = mood_byte;
              r.average_rate = avg_rate;
              run[n] = r;
              n++;
            end else begin
              phase = ST_REC;
            end
          end else if (fin) begin
            run[n] = reject(ERR_TRUNCATED, fin);
            n++;
          end else begin
            phase = phase + 3'd1;
          end
          count = '0;
        end else if (b == tag_val[0] || b == tag_val[1] || b == tag_val[2] ||
                     b == tag_val[3]) begin
          run[n] = reject(ERR_ORDER, fin);
          n++;
        end else begin
          run[n] = reject(ERR_UNKNOWN, fin);
          n++;
        end
      end else begin
        case (phase)
          ST_MODE, ST_MOOD: begin
            if (phase == ST_MODE) begin
              mode_byte = b;
            end else begin
              mood_byte = b;
            end
            phase = phase + 3'd1;
            if (fin) begin
              run[n] = reject(ERR_NO_END, fin);
              n++;
            end
          end
          ST_RATE: begin
            avg_rate = {avg_rate[7:0], b};
            count    = count + 4'd1;
            if (count >= RATE_BYTES) begin
              phase = ST_REC_TAG;
              count = '0;
              if (fin) begin
                run[n] = reject(ERR_NO_END, fin);
                n++;
              end
            end else if (fin) begin
              run[n] = reject(ERR_TRUNCATED, fin);
              n++;
            end
          end
          default: begin
            if (count < STAMP_BYTES) begin
              stamp = {stamp[55:0], b};
            end else if (count < PULSE_END) begin
              pulse = {pulse[7:0], b};
            end else begin
              steps = {steps[7:0], b};
            end
            count = count + 4'd1;
            if (count >= RECORD_BYTES) begin
              r = '0;
              r.result_kind  = KIND_RECORD;
              r.timestamp_ms = stamp;
              r.heart_rate   = pulse;
              r.step_count   = steps;
              run[n] = r;
              n++;
              phase = ST_REC_TAG;
              count = '0;
              if (fin) begin
                run[n] = reject(ERR_NO_END, fin);
                n++;
              end
            end else if (fin) begin
              run[n] = reject(ERR_TRUNCATED, fin);
              n++;
            end
          end
        endcase
      end
      if (fin && !skipping) begin
        phase = ST_MODE_TAG;
        count = '0;
      end
      if (n > 0) begin
        run[n - 1].last_of_run = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        expected_q.push_back(run[i]);
      end
    endfunction

    function void check_result(tsfp_result_t got);
      tsfp_result_t want_r;
      bit           bad;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result with nothing expected: %s", describe(got));
        end
        return;
      end
      want_r = expected_q.pop_front();
      bad = (got.result_kind !== want_r.result_kind) ||
            (got.timestamp_ms !== want_r.timestamp_ms) ||
            (got.heart_rate !== want_r.heart_rate) ||
            (got.step_count !== want_r.step_count) ||
            (got.mode_value !== want_r.mode_value) ||
            (got.mood_value !== want_r.mood_value) ||
            (got.average_rate !== want_r.average_rate) ||
            (got.error_code !== want_r.error_code) ||
            (got.last_of_run !== want_r.last_of_run);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch on result %0d", checked);
          $display("  expected %s", describe(want_r));
          $display("  actual   %s", describe(got));
        end
      end else begin
        kind_seen[int'(want_r.result_kind)]++;
        if (want_r.result_kind == KIND_REJECT) begin
          err_seen[int'(want_r.error_code)]++;
        end
      end
    endfunction
  endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 100ps
// Top of the tagged sensor frame parser bench: clock, reset, frame stimulus and result monitor.
module tb_top;
  import tsfp_pkg::*;
  import tsfp_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE       = 12;
  localparam int unsigned RANDOM_BYTES = 850;
  localparam int unsigned TAG_SETTINGS = 6;

  logic         clk_i        = 1'b0;
  logic         rst_ni       = 1'b0;
  logic         cfg_we_i     = 1'b0;
  logic [1:0]   cfg_index_i  = '0;
  logic [7:0]   cfg_data_i   = '0;
  logic         in_valid_i   = 1'b0;
  logic         in_stall_o;
  logic [7:0]   byte_value_i = '0;
  logic         frame_end_i  = 1'b0;
  logic         out_valid_o;
  logic         out_stall_i  = 1'b0;
  logic [1:0]   result_kind_o;
  logic [63:0]  timestamp_ms_o;
  logic [15:0]  heart_rate_o;
  logic [15:0]  step_count_o;
  logic [7:0]   mode_value_o;
  logic [7:0]   mood_value_o;
  logic [15:0]  average_rate_o;
  logic [1:0]   error_code_o;
  logic         last_of_run_o;
  tsfp_result_t seen_r;

  tsfp_scoreboard board = new();
  logic [8:0]     frame_q[$];
  bit             calm = 1'b0;
  int unsigned    cycles = 0;

  tagged_sensor_frame_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .byte_value_i   (byte_value_i),
    .frame_end_i    (frame_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .timestamp_ms_o (timestamp_ms_o),
    .heart_rate_o   (heart_rate_o),
    .step_count_o   (step_count_o),
    .mode_value_o   (mode_value_o),
    .mood_value_o   (mood_value_o),
    .average_rate_o (average_rate_o),
    .error_code_o   (error_code_o),
    .last_of_run_o  (last_of_run_o)
  );

  assign seen_r = {result_kind_o, timestamp_ms_o, heart_rate_o, step_count_o, mode_value_o,
                   mood_value_o, average_rate_o, error_code_o, last_of_run_o};

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(seen_r);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int unsigned hold;
    @(posedge clk_i);
    forever begin
      hold = pick_gap();
      out_stall_i <= (hold != 0);
      repeat ((hold == 0) ? $urandom_range(1, 6) : hold) @(posedge clk_i);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_value_i <= b;
    frame_end_i  <= fin;
    do @(posedge clk_i); while (in_stall_o);
    board.note_byte(b, fin);
  endtask

  function automatic void queue_byte(logic [7:0] b, logic fin);
    frame_q.push_back({fin, b});
  endfunction

  task automatic send_frame();
    frame_q[frame_q.size() - 1][8] = 1'b1;
    foreach (frame_q[i]) begin
      send_byte(frame_q[i][7:0], frame_q[i][8]);
    end
    frame_q.delete();
  endtask

  function automatic void queue_good_frame(int unsigned records, bit closed);
    queue_byte(board.tag_val[REG_MODE_TAG], 1'b0);
    queue_byte(8'($urandom), 1'b0);
    queue_byte(board.tag_val[REG_MOOD_TAG], 1'b0);
    queue_byte(8'($urandom), 1'b0);
    queue_byte(board.tag_val[REG_RATE_TAG], 1'b0);
    queue_byte(8'($urandom), 1'b0);
    queue_byte(8'($urandom), 1'b0);
    repeat (records) begin
      queue_byte(board.tag_val[REG_RECORD_TAG], 1'b0);
      repeat (RECORD_BYTES) queue_byte(8'($urandom), 1'b0);
    end
    if (closed) begin
      queue_byte(board.tag_val[REG_RECORD_TAG], 1'b0);
    end
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    board.set_tag(idx, val);
  endtask

  task automatic write_tags(input logic [7:0] m, mo, ra, rec);
    write_reg(REG_MODE_TAG, m);
    write_reg(REG_MOOD_TAG, mo);
    write_reg(REG_RATE_TAG, ra);
    write_reg(REG_RECORD_TAG, rec);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned goal;
    int unsigned kind;
    int unsigned recs;
    int unsigned cut;
    int unsigned pos;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Accepted frame with one record at the field extremes.
    queue_good_frame(0, 1'b0);
    frame_q[1] = 9'h0FF;
    frame_q[3] = 9'h000;
    frame_q[5] = 9'h080;
    frame_q[6] = 9'h001;
    queue_byte(board.tag_val[REG_RECORD_TAG], 1'b0);
    repeat (STAMP_BYTES) queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(board.tag_val[REG_RECORD_TAG], 1'b0);
    send_frame();
    // Out-of-order tag at the frame start, then the rest is skipped.
    queue_byte(board.tag_val[REG_MOOD_TAG], 1'b0);
    queue_byte(8'h00, 1'b0);
    send_frame();
    // Unknown tag, header tag cut off by the end, and a frame ending after a field.
    queue_byte(8'h55, 1'b0);
    send_frame();
    queue_byte(board.tag_val[REG_MODE_TAG], 1'b0);
    send_frame();
    queue_byte(board.tag_val[REG_MODE_TAG], 1'b0);
    queue_byte(8'h07, 1'b0);
    send_frame();

    for (int unsigned setting = 0; setting < TAG_SETTINGS; setting++) begin
      drain();
      case (setting)
        0: write_tags(8'd1, 8'd2, 8'd3, 8'd4);
        1: write_tags(8'h00, 8'hFF, 8'h80, 8'h7F);
        2: write_tags(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        3: write_tags(8'h00, 8'h00, 8'h01, 8'hFF);
        default: write_tags(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      goal = board.bytes_in + RANDOM_BYTES / TAG_SETTINGS;
      while (board.bytes_in < goal) begin
        calm = ($urandom_range(0, 7) == 0);
        kind = $urandom_range(0, 9);
        recs = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 4) : $urandom_range(0, 2);
        if (kind == 9) begin
          repeat ($urandom_range(1, 6)) begin
            queue_byte($urandom_range(0, 1) ? board.tag_val[$urandom_range(0, 3)] :
                       8'($urandom), ($urandom_range(0, 3) == 0));
          end
        end else begin
          queue_good_frame(recs, kind != 5);
          if (kind == 6) begin
            cut = $urandom_range(1, frame_q.size());
            while (frame_q.size() > cut) frame_q.pop_back();
          end else if (kind >= 7) begin
            pos = $urandom_range(0, frame_q.size() - 1);
            frame_q[pos] = {1'b0, $urandom_range(0, 1) ? board.tag_val[$urandom_range(0, 3)] :
                            8'($urandom)};
          end
        end
        send_frame();
      end
    end
    calm = 1'b0;
    drain();

    $display("Parsed %0d bytes under %0d tag settings; %0d results checked, %0d mismatched.",
             board.bytes_in, TAG_SETTINGS + 1, board.checked, board.mismatches);
    $display("Seen: %0d records, %0d accepts, rejects by cause %0d/%0d/%0d/%0d.",
             board.kind_seen[KIND_RECORD], board.kind_seen[KIND_ACCEPT],
             board.err_seen[ERR_ORDER], board.err_seen[ERR_UNKNOWN],
             board.err_seen[ERR_TRUNCATED], board.err_seen[ERR_NO_END]);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### tagged_sensor_frame_parser.f
src/tsfp_pkg.sv
src/tsfp_core.sv
src/tsfp_out_queue.sv
src/tagged_sensor_frame_parser.sv
verif/tsfp_tb_pkg.sv
verif/tb_top.sv
